@@ hw/rtl/meq_pkg.sv @@
`timescale 1ns / 1ps
package meq_pkg;

    localparam int QUEUE_DEPTH = 20;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    // code 4 + message 32 + time 32 + position 32 + mods 16
    localparam int ENTRY_W = 116;

    localparam logic [3:0] CODE_NULL     = 4'd0;
    localparam logic [3:0] CODE_KEY_DOWN = 4'd3;
    localparam logic [3:0] CODE_KEY_UP   = 4'd4;
    localparam logic [3:0] CODE_AUTO_KEY = 4'd5;
    localparam logic [15:0] BTN_UP_STATE = 16'h0080;

    localparam logic [1:0] CFG_SYS_MASK = 2'd0;
    localparam logic [1:0] CFG_DELAY    = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    typedef enum logic [1:0] {
        CMD_POST  = 2'd0,
        CMD_GET   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMPACT,
        ST_SHIFT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0]  code;
        logic [31:0] message;
        logic [31:0] time_stamp;
        logic [31:0] position;
        logic [15:0] mods;
    } entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  event_code;
        logic [31:0] message;
        logic [31:0] now_ticks;
        logic [15:0] where_h;
        logic [15:0] where_v;
        logic [15:0] modifiers;
        logic [15:0] event_mask;
        logic [15:0] stop_mask;
    } req_t;

    typedef struct packed {
        logic        status;
        logic        found;
        logic [3:0]  ev_what;
        logic [31:0] ev_message;
        logic [31:0] ev_when;
        logic [15:0] ev_where_h;
        logic [15:0] ev_where_v;
        logic [15:0] ev_modifiers;
    } rsp_t;

endpackage

@@ hw/rtl/meq_ram.sv @@
`timescale 1ns / 1ps
module meq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ hw/rtl/masked_event_queue_with_autorepeat_core.sv @@
`timescale 1ns / 1ps
// Masked event queue with keyboard auto-repeat.
// s_ channel: one request per command (post, get, peek, flush), valid/ready.
// m_ channel: exactly one response per request, valid/ready, held in an
// output register until taken; the next request is accepted only after
// the response for the current one has been taken.
// Entries live in one single-port-write, registered-read RAM, stored in
// order from slot 0 (oldest). Every request but a plain post walks the
// live entries, one RAM read per cycle. When the queue is full a post
// shifts the oldest entry out before appending, and a flush compacts kept
// entries in the same pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) land at once; the user
// must make them only while idle, which the block does not enforce. Reset
// empties the queue, drops the held key and restores the register defaults;
// RAM contents are not cleared since only slots below the count are ever
// read. A stalled receiver holds the response and blocks new requests.
module masked_event_queue_with_autorepeat_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  meq_pkg::req_t       s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output meq_pkg::rsp_t       m_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    localparam int IW = meq_pkg::IDX_W;
    localparam int CW = meq_pkg::CNT_W;

    meq_pkg::state_t state_reg, state_next;
    meq_pkg::req_t   req_reg, req_next;
    meq_pkg::rsp_t   rsp_reg, rsp_next;
    logic [15:0] sys_mask_reg, delay_reg, interval_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] key_msg_reg, key_msg_next;
    logic        key_valid_reg, key_valid_next;
    logic [31:0] repeat_reg, repeat_next;
    logic [31:0] cursor_reg, cursor_next;
    logic [15:0] mods_reg, mods_next;
    // scan index (address in flight) and compaction pointers
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic          rd_pend_reg, rd_pend_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    meq_pkg::entry_t   ram_wdata, ram_rdata;

    meq_ram #(.WIDTH(meq_pkg::ENTRY_W), .DEPTH(meq_pkg::QUEUE_DEPTH)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == meq_pkg::ST_IDLE);
    assign m_valid = (state_reg == meq_pkg::ST_OUT);
    assign m_data  = rsp_reg;

    logic [15:0] rd_bit;
    assign rd_bit = 16'd1 << ram_rdata.code;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sys_mask_reg <= 16'hFFEF;
            delay_reg    <= 16'd24;
            interval_reg <= 16'd6;
        end else if (cfg_we) begin
            unique case (cfg_index)
                meq_pkg::CFG_SYS_MASK: sys_mask_reg <= cfg_data;
                meq_pkg::CFG_DELAY:    delay_reg    <= cfg_data;
                meq_pkg::CFG_INTERVAL: interval_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= meq_pkg::ST_IDLE;
            count_reg     <= '0;
            key_msg_reg   <= '1;
            key_valid_reg <= 1'b0;
            repeat_reg    <= '0;
            cursor_reg    <= '0;
            mods_reg      <= meq_pkg::BTN_UP_STATE;
            rd_pend_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            key_msg_reg   <= key_msg_next;
            key_valid_reg <= key_valid_next;
            repeat_reg    <= repeat_next;
            cursor_reg    <= cursor_next;
            mods_reg      <= mods_next;
            rd_pend_reg   <= rd_pend_next;
        end
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        idx_reg <= idx_next;
        wr_reg  <= wr_next;
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        count_next     = count_reg;
        key_msg_next   = key_msg_reg;
        key_valid_next = key_valid_reg;
        repeat_next    = repeat_reg;
        cursor_next    = cursor_reg;
        mods_next      = mods_reg;
        idx_next       = idx_reg;
        wr_next        = wr_reg;
        rd_pend_next   = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = wr_reg[IW-1:0];
        ram_wdata      = ram_rdata;
        ram_raddr      = idx_reg[IW-1:0];

        unique case (state_reg)
            meq_pkg::ST_IDLE: begin
                if (s_valid) begin
                    req_next = s_data;
                    rsp_next = '0;
                    idx_next = '0;
                    wr_next  = '0;
                    if (s_data.cmd == meq_pkg::CMD_POST) begin
                        cursor_next = {s_data.where_v, s_data.where_h};
                        mods_next   = s_data.modifiers;
                        state_next  = meq_pkg::ST_OUT;
                        if ((s_data.event_code == meq_pkg::CODE_KEY_UP ||
                             s_data.event_code == meq_pkg::CODE_KEY_DOWN) &&
                            s_data.message[7:0] == 8'd0) begin
                            state_next = meq_pkg::ST_OUT;
                        end else begin
                            if (s_data.event_code == meq_pkg::CODE_KEY_UP) begin
                                key_valid_next = 1'b0;
                                key_msg_next   = '1;
                            end else if (s_data.event_code ==
                                         meq_pkg::CODE_KEY_DOWN) begin
                                key_valid_next = 1'b1;
                                key_msg_next   = s_data.message;
                                repeat_next    = s_data.now_ticks +
                                                 {16'd0, delay_reg};
                            end
                            if (!sys_mask_reg[s_data.event_code]) begin
                                rsp_next.status = 1'b1;
                            end else if (count_reg ==
                                         CW'(meq_pkg::QUEUE_DEPTH)) begin
                                // full: drop oldest by shifting down, then append
                                idx_next     = CW'(1);
                                ram_raddr    = '0;
                                rd_pend_next = 1'b0;
                                state_next   = meq_pkg::ST_SHIFT;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = count_reg[IW-1:0];
                                ram_wdata = '{code: s_data.event_code,
                                              message: s_data.message,
                                              time_stamp: s_data.now_ticks,
                                              position: {s_data.where_v,
                                                         s_data.where_h},
                                              mods: s_data.modifiers};
                                count_next = count_reg + CW'(1);
                            end
                        end
                    end else begin
                        state_next = meq_pkg::ST_SCAN;
                    end
                end
            end

            // one RAM read per cycle; the read issued last cycle is checked now
            meq_pkg::ST_SCAN: begin
                if (req_reg.cmd == meq_pkg::CMD_FLUSH) begin
                    if (rd_pend_reg && (rd_bit & req_reg.stop_mask) != 0) begin
                        // stop: keep this and the rest, compact from here
                        state_next = meq_pkg::ST_COMPACT;
                        idx_next   = idx_reg;
                        ram_raddr  = idx_reg[IW-1:0];
                        if (idx_reg < count_reg) begin
                            rd_pend_next = 1'b1;
                            idx_next     = idx_reg + CW'(1);
                        end
                        // entry just read is kept
                        ram_we     = 1'b1;
                        ram_waddr  = wr_reg[IW-1:0];
                        wr_next    = wr_reg + CW'(1);
                    end else begin
                        if (rd_pend_reg && (rd_bit & req_reg.event_mask) == 0) begin
                            ram_we    = 1'b1;
                            ram_waddr = wr_reg[IW-1:0];
                            wr_next   = wr_reg + CW'(1);
                        end
                        if (idx_reg < count_reg) begin
                            rd_pend_next = 1'b1;
                            idx_next     = idx_reg + CW'(1);
                        end else if (!rd_pend_reg) begin
                            count_next = wr_reg;
                            state_next = meq_pkg::ST_OUT;
                        end else begin
                            count_next = (rd_pend_reg &&
                                (rd_bit & req_reg.event_mask) == 0) ?
                                wr_reg + CW'(1) : wr_reg;
                            state_next = meq_pkg::ST_OUT;
                        end
                    end
                end else begin
                    if (rd_pend_reg && (rd_bit & req_reg.event_mask) != 0) begin
                        rsp_next.found        = 1'b1;
                        rsp_next.ev_what      = ram_rdata.code;
                        rsp_next.ev_message   = ram_rdata.message;
                        rsp_next.ev_when      = ram_rdata.time_stamp;
                        rsp_next.ev_where_h   = ram_rdata.position[15:0];
                        rsp_next.ev_where_v   = ram_rdata.position[31:16];
                        rsp_next.ev_modifiers = ram_rdata.mods;
                        if (req_reg.cmd == meq_pkg::CMD_GET) begin
                            // idx_reg points past the hit; shift the tail down
                            wr_next    = idx_reg - CW'(1);
                            ram_raddr  = idx_reg[IW-1:0];
                            rd_pend_next = 1'b0;
                            state_next = meq_pkg::ST_SHIFT;
                        end else begin
                            state_next = meq_pkg::ST_OUT;
                        end
                    end else if (idx_reg < count_reg) begin
                        rd_pend_next = 1'b1;
                        idx_next     = idx_reg + CW'(1);
                    end else begin
                        rsp_next.ev_when      = req_reg.now_ticks;
                        rsp_next.ev_where_h   = cursor_reg[15:0];
                        rsp_next.ev_where_v   = cursor_reg[31:16];
                        rsp_next.ev_modifiers = mods_reg;
                        if (req_reg.event_mask[meq_pkg::CODE_AUTO_KEY] &&
                            key_valid_reg &&
                            $signed(req_reg.now_ticks) > $signed(repeat_reg)) begin
                            repeat_next         = req_reg.now_ticks +
                                                  {16'd0, interval_reg};
                            rsp_next.found      = 1'b1;
                            rsp_next.ev_what    = meq_pkg::CODE_AUTO_KEY;
                            rsp_next.ev_message = key_msg_reg;
                        end
                        state_next = meq_pkg::ST_OUT;
                    end
                end
            end

            // flush tail copy: every remaining entry is kept
            meq_pkg::ST_COMPACT: begin
                if (rd_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[IW-1:0];
                    wr_next   = wr_reg + CW'(1);
                end
                if (idx_reg < count_reg) begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end else begin
                    count_next = rd_pend_reg ? wr_reg + CW'(1) : wr_reg;
                    state_next = meq_pkg::ST_OUT;
                end
            end

            // remove one slot: move idx..count-1 down to wr..; post appends after
            meq_pkg::ST_SHIFT: begin
                if (rd_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg[IW-1:0];
                    wr_next   = wr_reg + CW'(1);
                end
                if (idx_reg < count_reg) begin
                    rd_pend_next = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                end else if (rd_pend_reg) begin
                    rd_pend_next = 1'b0;
                end else begin
                    if (req_reg.cmd == meq_pkg::CMD_POST) begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg[IW-1:0];
                        ram_wdata = '{code: req_reg.event_code,
                                      message: req_reg.message,
                                      time_stamp: req_reg.now_ticks,
                                      position: {req_reg.where_v,
                                                 req_reg.where_h},
                                      mods: req_reg.modifiers};
                    end else begin
                        count_next = count_reg - CW'(1);
                    end
                    state_next = meq_pkg::ST_OUT;
                end
            end

            meq_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = meq_pkg::ST_IDLE;
                end
            end

            default: state_next = meq_pkg::ST_IDLE;
        endcase
    end

    // count never exceeds the queue depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(meq_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    // an accepted request always leaves the idle state
    a_leave_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted without work");

    // post and flush responses carry no event
    a_post_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (req_reg.cmd == meq_pkg::CMD_POST ||
                     req_reg.cmd == meq_pkg::CMD_FLUSH)) |-> !m_data.found)
        else $error("post or flush reported found");

    // no response while idle; response stays until taken
    a_out_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("response and request overlap");
endmodule
